[design/vlt_pkg.sv]
package vlt_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LIGHTING_EN,
        REG_AMBIENT,
        REG_SUN_COLOR,
        REG_SUN_DIR,
        REG_POINT_X,
        REG_POINT_Y,
        REG_POINT_Z,
        REG_INTENSITY
    } cfg_idx_t;

    // square root unit: one root bit per stage
    localparam int SQ_IN_W   = 60;
    localparam int SQ_ROOT_W = SQ_IN_W / 2;

    // divider unit: one quotient bit per stage
    localparam int DV_N_W = 48;
    localparam int DV_D_W = 30;
    localparam int DV_Q_W = 20;
    localparam int DV_C_W = DV_D_W + DV_Q_W;

    // stage registers from the accept edge to the result strobe
    localparam int PIPE_DEPTH = 83;

    localparam logic [14:0]        ATT_K    = 15'd24904;
    localparam logic [15:0]        LAMP_W_R = 16'd62016;
    localparam logic [15:0]        LAMP_W_G = 16'd53530;
    localparam logic [15:0]        LAMP_W_B = 16'd35904;
    localparam logic signed [15:0] Q_ONE14  = 16'sd16384;

    typedef struct packed {
        logic [7:0]  cr;
        logic [7:0]  cg;
        logic [7:0]  cb;
        logic [7:0]  ca;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        nzero;
        logic [24:0] dx;
        logic [24:0] dy;
        logic [24:0] dz;
        logic        dzero;
    } geo_t;

    typedef struct packed {
        geo_t        g;
        logic [28:0] dist16;
    } geo_dist_t;

    typedef struct packed {
        logic [31:0] rgba;
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic [24:0] dx;
        logic [24:0] dy;
        logic [24:0] dz;
        logic        dzero;
        logic [28:0] dist16;
        logic [19:0] att;
    } shd_t;

    typedef struct packed {
        logic [31:0] rgba;
        logic [19:0] att;
        logic        lamp_ok;
        logic [17:0] wrap16;
        logic [26:0] er;
        logic [26:0] eg;
        logic [26:0] eb;
    } tint_t;

endpackage

[design/vlt_isqrt.sv]
module vlt_isqrt
    import vlt_pkg::*;
(
    input  logic                 clk,
    input  logic [SQ_IN_W-1:0]   radicand,
    output logic [SQ_ROOT_W-1:0] root
);

    logic [SQ_IN_W-1:0] x_reg [SQ_ROOT_W];
    logic [SQ_IN_W-1:0] r_reg [SQ_ROOT_W];

    for (genvar j = 0; j < SQ_ROOT_W; j++)
    begin : g_stage
        logic [SQ_IN_W-1:0] x_in;
        logic [SQ_IN_W-1:0] r_in;
        logic [SQ_IN_W-1:0] bit_val;
        logic [SQ_IN_W-1:0] x_next;
        logic [SQ_IN_W-1:0] r_next;
        logic [SQ_IN_W:0]   trial;

        if (j == 0)
        begin : g_first
            assign x_in = radicand;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign x_in = x_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        assign bit_val = {{(SQ_IN_W-1){1'b0}}, 1'b1} << (SQ_IN_W - 2 - 2 * j);
        assign trial   = {1'b0, r_in} + {1'b0, bit_val};

        always_comb
        begin
            if ({1'b0, x_in} >= trial)
            begin
                x_next = x_in - trial[SQ_IN_W-1:0];
                r_next = (r_in >> 1) + bit_val;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[j] <= x_next;
            r_reg[j] <= r_next;
        end
    end

    assign root = r_reg[SQ_ROOT_W-1][SQ_ROOT_W-1:0];

endmodule

[design/vlt_div.sv]
module vlt_div
    import vlt_pkg::*;
(
    input  logic              clk,
    input  logic [DV_N_W-1:0] dividend,
    input  logic [DV_D_W-1:0] divisor,
    output logic [DV_Q_W-1:0] quotient
);

    logic [DV_N_W-1:0] rem_reg [DV_Q_W];
    logic [DV_D_W-1:0] div_reg [DV_Q_W];
    logic [DV_Q_W-1:0] q_reg   [DV_Q_W];

    for (genvar j = 0; j < DV_Q_W; j++)
    begin : g_stage
        logic [DV_N_W-1:0] rem_in;
        logic [DV_D_W-1:0] div_in;
        logic [DV_Q_W-1:0] q_in;
        logic [DV_C_W-1:0] shifted;
        logic [DV_C_W-1:0] rem_ext;
        logic [DV_C_W-1:0] diff;
        logic              take;
        logic [DV_N_W-1:0] rem_next;
        logic [DV_Q_W-1:0] q_next;

        if (j == 0)
        begin : g_first
            assign rem_in = dividend;
            assign div_in = divisor;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign div_in = div_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        // trial subtract of the divisor at quotient bit DV_Q_W-1-j
        assign shifted  = {{DV_Q_W{1'b0}}, div_in} << (DV_Q_W - 1 - j);
        assign rem_ext  = {{(DV_C_W-DV_N_W){1'b0}}, rem_in};
        assign diff     = rem_ext - shifted;
        assign take     = rem_ext >= shifted;
        assign rem_next = take ? diff[DV_N_W-1:0] : rem_in;
        assign q_next   = {q_in[DV_Q_W-2:0], take};

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            div_reg[j] <= div_in;
            q_reg[j]   <= q_next;
        end
    end

    assign quotient = q_reg[DV_Q_W-1];

endmodule

[design/vertex_light_tint.sv]
// vertex_light_tint: per-vertex wrap diffuse lighting with a sun and one point lamp
//
// input channel: a vertex word (base colour, normal, world position) is taken at
// each rising edge where start is high and busy is low; busy never rises, so one
// vertex can enter every cycle
// result channel: done is high for exactly one cycle with lit_r/g/b/a valid; done
// and lit_r/g/b/a are driven from registers at the end of the pipeline; results
// leave in input order
// throughput: one vertex per cycle; the two 30-stage square roots (one root bit
// per stage) run side by side and are followed by two ranks of 20-stage dividers
// (one quotient bit per stage) in series
// the receiver cannot stall; the pipeline advances every cycle
// configuration: cfg_write with cfg_index and cfg_data writes one register in a
// cycle; write only while no vertex is in flight
// reset: clears all valid bits and loads the default colours, lighting on, lamp off
module vertex_light_tint
    import vlt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         base_r,
    input  logic [7:0]         base_g,
    input  logic [7:0]         base_b,
    input  logic [7:0]         base_a,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] pos_z,
    output logic               done,
    output logic [7:0]         lit_r,
    output logic [7:0]         lit_g,
    output logic [7:0]         lit_b,
    output logic [7:0]         lit_a
);

    // ---------------- configuration registers ----------------
    logic        lighting_en_reg;
    logic [23:0] ambient_reg;
    logic [23:0] sun_color_reg;
    logic [47:0] sun_dir_reg;
    logic [23:0] point_x_reg;
    logic [23:0] point_y_reg;
    logic [23:0] point_z_reg;
    logic [15:0] intensity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lighting_en_reg <= 1'b1;
            ambient_reg     <= 24'h2A3044;
            sun_color_reg   <= 24'hFFD6A0;
            sun_dir_reg     <= '0;
            point_x_reg     <= '0;
            point_y_reg     <= '0;
            point_z_reg     <= '0;
            intensity_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LIGHTING_EN: lighting_en_reg <= cfg_data[0];
                REG_AMBIENT:     ambient_reg     <= cfg_data[23:0];
                REG_SUN_COLOR:   sun_color_reg   <= cfg_data[23:0];
                REG_SUN_DIR:     sun_dir_reg     <= cfg_data;
                REG_POINT_X:     point_x_reg     <= cfg_data[23:0];
                REG_POINT_Y:     point_y_reg     <= cfg_data[23:0];
                REG_POINT_Z:     point_z_reg     <= cfg_data[23:0];
                REG_INTENSITY:   intensity_reg   <= cfg_data[15:0];
            endcase
        end
    end

    // ---------------- valid bits ----------------
    logic                  accept;
    logic [PIPE_DEPTH-1:0] valid_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
    end

    // ---------------- stage 0: capture ----------------
    logic [31:0] rgba_s0_reg;
    logic [15:0] nx_s0_reg, ny_s0_reg, nz_s0_reg;
    logic [23:0] px_s0_reg, py_s0_reg, pz_s0_reg;

    always_ff @(posedge clk)
    begin
        rgba_s0_reg <= {base_r, base_g, base_b, base_a};
        nx_s0_reg   <= normal_x;
        ny_s0_reg   <= normal_y;
        nz_s0_reg   <= normal_z;
        px_s0_reg   <= pos_x;
        py_s0_reg   <= pos_y;
        pz_s0_reg   <= pos_z;
    end

    // ---------------- stage 1: squares of the normal, lamp offset ----------------
    logic signed [31:0] sqx, sqy, sqz;
    logic [30:0]        nnx_s1_reg, nny_s1_reg, nnz_s1_reg;
    geo_t               geo_s1_next, geo_s1_reg;

    assign sqx = $signed(nx_s0_reg) * $signed(nx_s0_reg);
    assign sqy = $signed(ny_s0_reg) * $signed(ny_s0_reg);
    assign sqz = $signed(nz_s0_reg) * $signed(nz_s0_reg);

    always_comb
    begin
        geo_s1_next.cr    = rgba_s0_reg[31:24];
        geo_s1_next.cg    = rgba_s0_reg[23:16];
        geo_s1_next.cb    = rgba_s0_reg[15:8];
        geo_s1_next.ca    = rgba_s0_reg[7:0];
        geo_s1_next.nx    = nx_s0_reg;
        geo_s1_next.ny    = ny_s0_reg;
        geo_s1_next.nz    = nz_s0_reg;
        geo_s1_next.nzero = (nx_s0_reg == '0) && (ny_s0_reg == '0) && (nz_s0_reg == '0);
        geo_s1_next.dx    = {point_x_reg[23], point_x_reg} - {px_s0_reg[23], px_s0_reg};
        geo_s1_next.dy    = {point_y_reg[23], point_y_reg} - {py_s0_reg[23], py_s0_reg};
        geo_s1_next.dz    = {point_z_reg[23], point_z_reg} - {pz_s0_reg[23], pz_s0_reg};
        geo_s1_next.dzero = (geo_s1_next.dx == '0) && (geo_s1_next.dy == '0)
                            && (geo_s1_next.dz == '0);
    end

    always_ff @(posedge clk)
    begin
        nnx_s1_reg <= sqx[30:0];
        nny_s1_reg <= sqy[30:0];
        nnz_s1_reg <= sqz[30:0];
        geo_s1_reg <= geo_s1_next;
    end

    // ---------------- stage 2: squared length, squares of the offset ----------------
    logic signed [49:0] ddx, ddy, ddz;
    logic [31:0]        l2_s2_reg;
    logic [48:0]        ddx_s2_reg, ddy_s2_reg, ddz_s2_reg;
    geo_t               geo_s2_reg;

    assign ddx = $signed(geo_s1_reg.dx) * $signed(geo_s1_reg.dx);
    assign ddy = $signed(geo_s1_reg.dy) * $signed(geo_s1_reg.dy);
    assign ddz = $signed(geo_s1_reg.dz) * $signed(geo_s1_reg.dz);

    always_ff @(posedge clk)
    begin
        l2_s2_reg  <= {1'b0, nnx_s1_reg} + {1'b0, nny_s1_reg} + {1'b0, nnz_s1_reg};
        ddx_s2_reg <= ddx[48:0];
        ddy_s2_reg <= ddy[48:0];
        ddz_s2_reg <= ddz[48:0];
        geo_s2_reg <= geo_s1_reg;
    end

    // ---------------- stage 3: squared distance ----------------
    logic [31:0] l2_s3_reg;
    logic [49:0] d2_s3_reg;
    geo_t        geo_s3_reg;

    always_ff @(posedge clk)
    begin
        l2_s3_reg  <= l2_s2_reg;
        d2_s3_reg  <= {1'b0, ddx_s2_reg} + {1'b0, ddy_s2_reg} + {1'b0, ddz_s2_reg};
        geo_s3_reg <= geo_s2_reg;
    end

    // ---------------- stages 4..33: square roots ----------------
    logic [SQ_ROOT_W-1:0] len_root;
    logic [SQ_ROOT_W-1:0] dist_root;
    geo_t                 a_pipe_reg [SQ_ROOT_W];

    vlt_isqrt u_len_sqrt (
        .clk      (clk),
        .radicand ({l2_s3_reg, 28'd0}),
        .root     (len_root)
    );

    vlt_isqrt u_dist_sqrt (
        .clk      (clk),
        .radicand ({2'd0, d2_s3_reg, 8'd0}),
        .root     (dist_root)
    );

    always_ff @(posedge clk)
    begin
        a_pipe_reg[0] <= geo_s3_reg;
        for (int k = 1; k < SQ_ROOT_W; k++)
            a_pipe_reg[k] <= a_pipe_reg[k-1];
    end

    // ---------------- stage 34: attenuation divisor ----------------
    logic [43:0]       dist_k;
    logic [29:0]       len_s34_reg;
    logic [28:0]       dist_s34_reg;
    logic [28:0]       den_s34_reg;
    geo_t              geo_s34_reg;
    logic [15:0]       magx, magy, magz;

    assign dist_k = dist_root[28:0] * ATT_K;

    always_ff @(posedge clk)
    begin
        len_s34_reg  <= len_root;
        dist_s34_reg <= dist_root[28:0];
        den_s34_reg  <= {1'b0, dist_k[43:16]} + 29'd65536;
        geo_s34_reg  <= a_pipe_reg[SQ_ROOT_W-1];
    end

    assign magx = geo_s34_reg.nx[15] ? 16'(-geo_s34_reg.nx) : geo_s34_reg.nx;
    assign magy = geo_s34_reg.ny[15] ? 16'(-geo_s34_reg.ny) : geo_s34_reg.ny;
    assign magz = geo_s34_reg.nz[15] ? 16'(-geo_s34_reg.nz) : geo_s34_reg.nz;

    // ---------------- stages 35..54: unit normal and attenuation ----------------
    logic [DV_Q_W-1:0] qx, qy, qz, att_q;
    geo_dist_t         b_pipe_reg [DV_Q_W];

    vlt_div u_div_x (
        .clk      (clk),
        .dividend ({4'd0, magx, 28'd0}),
        .divisor  (len_s34_reg),
        .quotient (qx)
    );

    vlt_div u_div_y (
        .clk      (clk),
        .dividend ({4'd0, magy, 28'd0}),
        .divisor  (len_s34_reg),
        .quotient (qy)
    );

    vlt_div u_div_z (
        .clk      (clk),
        .dividend ({4'd0, magz, 28'd0}),
        .divisor  (len_s34_reg),
        .quotient (qz)
    );

    vlt_div u_div_att (
        .clk      (clk),
        .dividend ({12'd0, intensity_reg, 20'd0}),
        .divisor  ({1'b0, den_s34_reg}),
        .quotient (att_q)
    );

    always_ff @(posedge clk)
    begin
        b_pipe_reg[0] <= {geo_s34_reg, dist_s34_reg};
        for (int k = 1; k < DV_Q_W; k++)
            b_pipe_reg[k] <= b_pipe_reg[k-1];
    end

    // ---------------- stage 55: signed unit normal ----------------
    geo_dist_t         b_last;
    logic signed [15:0] uqx, uqy, uqz;
    shd_t               shd_s55_next, shd_s55_reg;

    assign b_last = b_pipe_reg[DV_Q_W-1];
    assign uqx = {1'b0, qx[14:0]};
    assign uqy = {1'b0, qy[14:0]};
    assign uqz = {1'b0, qz[14:0]};

    always_comb
    begin
        shd_s55_next.rgba   = {b_last.g.cr, b_last.g.cg, b_last.g.cb, b_last.g.ca};
        // a zero normal points straight up
        if (b_last.g.nzero)
        begin
            shd_s55_next.ux = '0;
            shd_s55_next.uy = Q_ONE14;
            shd_s55_next.uz = '0;
        end
        else
        begin
            shd_s55_next.ux = b_last.g.nx[15] ? -uqx : uqx;
            shd_s55_next.uy = b_last.g.ny[15] ? -uqy : uqy;
            shd_s55_next.uz = b_last.g.nz[15] ? -uqz : uqz;
        end
        shd_s55_next.dx     = b_last.g.dx;
        shd_s55_next.dy     = b_last.g.dy;
        shd_s55_next.dz     = b_last.g.dz;
        shd_s55_next.dzero  = b_last.g.dzero;
        shd_s55_next.dist16 = b_last.dist16;
        shd_s55_next.att    = att_q;
    end

    always_ff @(posedge clk)
        shd_s55_reg <= shd_s55_next;

    // ---------------- stage 56: dot products ----------------
    logic signed [15:0] sdx, sdy, sdz;
    logic signed [40:0] pdx_s56_reg, pdy_s56_reg, pdz_s56_reg;
    logic signed [31:0] psx_s56_reg, psy_s56_reg, psz_s56_reg;
    shd_t               shd_s56_reg;

    assign sdx = $signed(sun_dir_reg[47:32]);
    assign sdy = $signed(sun_dir_reg[31:16]);
    assign sdz = $signed(sun_dir_reg[15:0]);

    always_ff @(posedge clk)
    begin
        pdx_s56_reg <= $signed(shd_s55_reg.ux) * $signed(shd_s55_reg.dx);
        pdy_s56_reg <= $signed(shd_s55_reg.uy) * $signed(shd_s55_reg.dy);
        pdz_s56_reg <= $signed(shd_s55_reg.uz) * $signed(shd_s55_reg.dz);
        psx_s56_reg <= $signed(shd_s55_reg.ux) * sdx;
        psy_s56_reg <= $signed(shd_s55_reg.uy) * sdy;
        psz_s56_reg <= $signed(shd_s55_reg.uz) * sdz;
        shd_s56_reg <= shd_s55_reg;
    end

    // ---------------- stage 57: sums ----------------
    logic signed [42:0] s_s57_reg;
    logic signed [33:0] sps_s57_reg;
    shd_t               shd_s57_reg;

    always_ff @(posedge clk)
    begin
        s_s57_reg   <= 43'(pdx_s56_reg) + 43'(pdy_s56_reg) + 43'(pdz_s56_reg);
        sps_s57_reg <= 34'(psx_s56_reg) + 34'(psy_s56_reg) + 34'(psz_s56_reg);
        shd_s57_reg <= shd_s56_reg;
    end

    // ---------------- stages 58..77: lamp cosine over distance ----------------
    logic [DV_Q_W-1:0]  spot_q;
    logic signed [34:0] wrap29;
    tint_t              tint0_next, tint1_next;
    tint_t              c_pipe_reg [DV_Q_W];

    vlt_div u_div_spot (
        .clk      (clk),
        .dividend ({s_s57_reg[41:0], 6'd0}),
        .divisor  ({1'b0, shd_s57_reg.dist16}),
        .quotient (spot_q)
    );

    // wrap diffuse: one minus the dot with the sun, clamped at zero
    assign wrap29 = 35'sd268435456 - 35'(sps_s57_reg);

    always_comb
    begin
        tint0_next.rgba    = shd_s57_reg.rgba;
        tint0_next.att     = shd_s57_reg.att;
        tint0_next.lamp_ok = (s_s57_reg > 43'sd0) && !shd_s57_reg.dzero
                             && (intensity_reg != '0);
        tint0_next.wrap16  = wrap29[34] ? '0 : wrap29[30:13];
        tint0_next.er      = '0;
        tint0_next.eg      = '0;
        tint0_next.eb      = '0;
    end

    always_comb
    begin
        tint1_next    = c_pipe_reg[0];
        tint1_next.er = {3'd0, ambient_reg[23:16], 16'd0}
                        + 27'(sun_color_reg[23:16] * c_pipe_reg[0].wrap16);
        tint1_next.eg = {3'd0, ambient_reg[15:8], 16'd0}
                        + 27'(sun_color_reg[15:8] * c_pipe_reg[0].wrap16);
        tint1_next.eb = {3'd0, ambient_reg[7:0], 16'd0}
                        + 27'(sun_color_reg[7:0] * c_pipe_reg[0].wrap16);
    end

    always_ff @(posedge clk)
    begin
        c_pipe_reg[0] <= tint0_next;
        c_pipe_reg[1] <= tint1_next;
        for (int k = 2; k < DV_Q_W; k++)
            c_pipe_reg[k] <= c_pipe_reg[k-1];
    end

    // ---------------- stage 78: lamp strength ----------------
    tint_t       c_last;
    logic [37:0] lamp_prod;
    logic [21:0] lamp16_s78_reg;
    tint_t       tint_s78_reg;

    assign c_last    = c_pipe_reg[DV_Q_W-1];
    assign lamp_prod = spot_q[17:0] * c_last.att;

    always_ff @(posedge clk)
    begin
        lamp16_s78_reg <= lamp_prod[37:16];
        tint_s78_reg   <= c_last;
    end

    // ---------------- stage 79: warm weights ----------------
    logic [37:0] wr_prod, wg_prod, wb_prod;
    logic [29:0] ladd_r_s79_reg, ladd_g_s79_reg, ladd_b_s79_reg;
    tint_t       tint_s79_reg;

    assign wr_prod = LAMP_W_R * lamp16_s78_reg;
    assign wg_prod = LAMP_W_G * lamp16_s78_reg;
    assign wb_prod = LAMP_W_B * lamp16_s78_reg;

    always_ff @(posedge clk)
    begin
        ladd_r_s79_reg <= wr_prod[37:8];
        ladd_g_s79_reg <= wg_prod[37:8];
        ladd_b_s79_reg <= wb_prod[37:8];
        tint_s79_reg   <= tint_s78_reg;
    end

    // ---------------- stage 80: light factors ----------------
    logic [30:0] er_s80_reg, eg_s80_reg, eb_s80_reg;
    logic [31:0] rgba_s80_reg;

    always_ff @(posedge clk)
    begin
        er_s80_reg   <= {4'd0, tint_s79_reg.er}
                        + (tint_s79_reg.lamp_ok ? {1'b0, ladd_r_s79_reg} : 31'd0);
        eg_s80_reg   <= {4'd0, tint_s79_reg.eg}
                        + (tint_s79_reg.lamp_ok ? {1'b0, ladd_g_s79_reg} : 31'd0);
        eb_s80_reg   <= {4'd0, tint_s79_reg.eb}
                        + (tint_s79_reg.lamp_ok ? {1'b0, ladd_b_s79_reg} : 31'd0);
        rgba_s80_reg <= tint_s79_reg.rgba;
    end

    // ---------------- stage 81: scale base colour ----------------
    logic [38:0] pr_s81_reg, pg_s81_reg, pb_s81_reg;
    logic [31:0] rgba_s81_reg;

    always_ff @(posedge clk)
    begin
        pr_s81_reg   <= rgba_s80_reg[31:24] * er_s80_reg;
        pg_s81_reg   <= rgba_s80_reg[23:16] * eg_s80_reg;
        pb_s81_reg   <= rgba_s80_reg[15:8] * eb_s80_reg;
        rgba_s81_reg <= rgba_s80_reg;
    end

    // ---------------- stage 82: divide by 255, saturate, output ----------------
    logic [16:0] tr, tg, tb;
    logic [7:0]  shr, shg, shb;
    logic [7:0]  lit_r_reg, lit_g_reg, lit_b_reg, lit_a_reg;

    // floor(y / 255) for y below 65280 as (y + y / 256 + 1) / 256
    assign tr = {1'b0, pr_s81_reg[31:16]} + {9'd0, pr_s81_reg[31:24]} + 17'd1;
    assign tg = {1'b0, pg_s81_reg[31:16]} + {9'd0, pg_s81_reg[31:24]} + 17'd1;
    assign tb = {1'b0, pb_s81_reg[31:16]} + {9'd0, pb_s81_reg[31:24]} + 17'd1;

    assign shr = (pr_s81_reg[38:16] >= 23'd65280) ? 8'd255 : tr[15:8];
    assign shg = (pg_s81_reg[38:16] >= 23'd65280) ? 8'd255 : tg[15:8];
    assign shb = (pb_s81_reg[38:16] >= 23'd65280) ? 8'd255 : tb[15:8];

    always_ff @(posedge clk)
    begin
        lit_r_reg <= lighting_en_reg ? shr : rgba_s81_reg[31:24];
        lit_g_reg <= lighting_en_reg ? shg : rgba_s81_reg[23:16];
        lit_b_reg <= lighting_en_reg ? shb : rgba_s81_reg[15:8];
        lit_a_reg <= rgba_s81_reg[7:0];
    end

    assign done  = valid_reg[PIPE_DEPTH-1];
    assign lit_r = lit_r_reg;
    assign lit_g = lit_g_reg;
    assign lit_b = lit_b_reg;
    assign lit_a = lit_a_reg;

    // ---------------- assertions ----------------
    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result strobe without a matching input word");

    a_alpha_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (lit_a == $past(base_a, PIPE_DEPTH)))
        else $error("alpha not carried with its word");

    a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[33] && !a_pipe_reg[SQ_ROOT_W-1].nzero) |-> (len_root >= 30'd16384))
        else $error("normal length root below one for a nonzero normal");

endmodule

[test/tb.sv]
module tb;
    import vlt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]  r, g, b, a;
        logic [15:0] nx, ny, nz;
        logic [23:0] px, py, pz;
    } vertex_t;

    typedef struct {
        logic [7:0] r, g, b, a;
    } color_t;

    typedef struct {
        logic        en;
        logic [23:0] amb;
        logic [23:0] sun;
        logic [47:0] dir;
        logic [23:0] lx, ly, lz;
        logic [15:0] inten;
    } light_cfg_t;

    // one directed row: setting to use, typed answer where fixed is set
    typedef struct {
        int      setting;
        bit      fixed;
        vertex_t v;
        color_t  c;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        start;
    logic        busy;
    logic [7:0]  base_r, base_g, base_b, base_a;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic signed [23:0] pos_x, pos_y, pos_z;
    logic        done;
    logic [7:0]  lit_r, lit_g, lit_b, lit_a;
    logic        busy_s;

    color_t      lit_pending[$];
    light_cfg_t  cur;
    light_cfg_t  presets[3];
    row_t        rows[$];
    int          errors;

    vertex_light_tint u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .base_r(base_r), .base_g(base_g), .base_b(base_b), .base_a(base_a),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .done(done), .lit_r(lit_r), .lit_g(lit_g), .lit_b(lit_b), .lit_a(lit_a)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // busy only moves after a rising edge, so its value here holds at the next one
    always @(negedge clk)
    begin
        busy_s = busy;
    end

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint c, longint unsigned len);
        longint unsigned mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q = longint'((mag << 28) / len);
        return (c < 0) ? -q : q;
    endfunction

    function automatic logic [7:0] scale_channel(logic [7:0] base, longint unsigned e);
        longint unsigned v;
        v = (longint'(base) * e) / (255 * 65536);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic color_t light_vertex(vertex_t v);
        color_t o;
        longint nx, ny, nz, ux, uy, uz, sx, sy, sz, dot, w29, dx, dy, dz, s;
        longint unsigned len, w16, er, eg, eb, d2, dlen, spot, den, att, lamp;
        o.a = v.a;
        if (!cur.en)
        begin
            o.r = v.r;
            o.g = v.g;
            o.b = v.b;
            return o;
        end
        nx = $signed(v.nx);
        ny = $signed(v.ny);
        nz = $signed(v.nz);
        if (nx == 0 && ny == 0 && nz == 0)
        begin
            ux = 0;
            uy = 16384;
            uz = 0;
        end
        else
        begin
            len = root64(longint'(nx * nx + ny * ny + nz * nz) << 28);
            ux = unit_part(nx, len);
            uy = unit_part(ny, len);
            uz = unit_part(nz, len);
        end
        sx = $signed(cur.dir[47:32]);
        sy = $signed(cur.dir[31:16]);
        sz = $signed(cur.dir[15:0]);
        dot = -(ux * sx + uy * sy + uz * sz);
        w29 = dot + (64'sd1 <<< 28);
        if (w29 < 0)
            w29 = 0;
        w16 = longint'(w29) >> 13;
        er = (longint'(cur.amb[23:16]) << 16) + longint'(cur.sun[23:16]) * w16;
        eg = (longint'(cur.amb[15:8]) << 16) + longint'(cur.sun[15:8]) * w16;
        eb = (longint'(cur.amb[7:0]) << 16) + longint'(cur.sun[7:0]) * w16;
        if (cur.inten != 0)
        begin
            dx = longint'($signed(cur.lx)) - longint'($signed(v.px));
            dy = longint'($signed(cur.ly)) - longint'($signed(v.py));
            dz = longint'($signed(cur.lz)) - longint'($signed(v.pz));
            if (dx != 0 || dy != 0 || dz != 0)
            begin
                d2 = dx * dx + dy * dy + dz * dz;
                dlen = root64(d2 << 8);
                s = ux * dx + uy * dy + uz * dz;
                if (s > 0)
                begin
                    spot = (longint'(s) * 64) / dlen;
                    den = 65536 + ((dlen * 24904) >> 16);
                    att = (longint'(cur.inten) << 20) / den;
                    lamp = (spot * att) >> 16;
                    er += (longint'(LAMP_W_R) * lamp) >> 8;
                    eg += (longint'(LAMP_W_G) * lamp) >> 8;
                    eb += (longint'(LAMP_W_B) * lamp) >> 8;
                end
            end
        end
        o.r = scale_channel(v.r, er);
        o.g = scale_channel(v.g, eg);
        o.b = scale_channel(v.b, eb);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        color_t w;
        if (rst_n && done)
        begin
            if (lit_pending.size() == 0)
            begin
                $display("unexpected word at %0t", $realtime);
                errors++;
            end
            else
            begin
                w = lit_pending.pop_front();
                if (lit_r !== w.r) report_mismatch("lit_r", lit_r, w.r);
                if (lit_g !== w.g) report_mismatch("lit_g", lit_g, w.g);
                if (lit_b !== w.b) report_mismatch("lit_b", lit_b, w.b);
                if (lit_a !== w.a) report_mismatch("lit_a", lit_a, w.a);
            end
        end
    end

    task automatic drain();
        while (lit_pending.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [47:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_setting(light_cfg_t c);
        drain();
        write_reg(REG_LIGHTING_EN, {47'd0, c.en});
        write_reg(REG_AMBIENT, {24'd0, c.amb});
        write_reg(REG_SUN_COLOR, {24'd0, c.sun});
        write_reg(REG_SUN_DIR, c.dir);
        write_reg(REG_POINT_X, {24'd0, c.lx});
        write_reg(REG_POINT_Y, {24'd0, c.ly});
        write_reg(REG_POINT_Z, {24'd0, c.lz});
        write_reg(REG_INTENSITY, {32'd0, c.inten});
        cfg_write <= 1'b0;
        cur = c;
        @(posedge clk);
    endtask

    // start stays high across back-to-back words and drops only for a gap
    task automatic send_vertex(vertex_t v, color_t want, bit use_want, bit steady);
        int pick;
        start    <= 1'b1;
        base_r   <= v.r;
        base_g   <= v.g;
        base_b   <= v.b;
        base_a   <= v.a;
        normal_x <= v.nx;
        normal_y <= v.ny;
        normal_z <= v.nz;
        pos_x    <= v.px;
        pos_y    <= v.py;
        pos_z    <= v.pz;
        do
            @(posedge clk);
        while (busy_s);
        lit_pending.push_back(use_want ? want : light_vertex(v));
        pick = $urandom_range(0, 99);
        if (!steady && pick >= 50)
        begin
            start <= 1'b0;
            repeat ((pick < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40))
                @(posedge clk);
        end
    endtask

    function automatic light_cfg_t random_setting(int k);
        light_cfg_t c;
        logic [15:0] one;
        c.en = ($urandom_range(0, 9) != 0);
        c.amb = 24'($urandom);
        c.sun = 24'($urandom);
        one = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        case ($urandom_range(0, 3))
            0: c.dir = {one, 32'd0};
            1: c.dir = {16'd0, one, 16'd0};
            2: c.dir = {32'd0, one};
            default: c.dir = 48'({$urandom, $urandom});
        endcase
        c.lx = 24'($urandom);
        c.ly = 24'($urandom);
        c.lz = 24'($urandom);
        c.inten = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
        if (k == 0)
            c = '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 48'h7FFF7FFF7FFF, 24'h7FFFFF,
                  24'h7FFFFF, 24'h7FFFFF, 16'hFFFF};
        else if (k == 1)
            c = '{1'b1, 24'h0, 24'h0, 48'h800080008000, 24'h800000,
                  24'h800000, 24'h800000, 16'h0001};
        return c;
    endfunction

    function automatic logic [15:0] random_normal();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 16'($urandom);
        else if (pick < 85)
            return 16'($signed($urandom_range(0, 8)) - 4);
        return 16'd0;
    endfunction

    function automatic logic [23:0] random_pos(logic [23:0] light, bit hit);
        int pick;
        if (hit)
            return light;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return light + 24'($signed($urandom_range(0, 32768)) - 16384);
        return 24'($urandom);
    endfunction

    initial
    begin
        vertex_t v;
        color_t  none;
        bit hit;
        bit steady;
        int last;

        errors    = 0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_LIGHTING_EN;
        cfg_data  = '0;
        start     = 1'b0;
        {base_r, base_g, base_b, base_a} = '0;
        {normal_x, normal_y, normal_z} = '0;
        {pos_x, pos_y, pos_z} = '0;
        none = '{0, 0, 0, 0};
        cur = '{1'b1, 24'h2A3044, 24'hFFD6A0, 48'd0, 24'd0, 24'd0, 24'd0, 16'd0};
        presets[0] = cur;
        presets[1] = '{1'b0, 24'h2A3044, 24'hFFD6A0, 48'd0, 24'd0, 24'd0, 24'd0, 16'd0};
        // sun straight down, full-strength lamp at the origin
        presets[2] = '{1'b1, 24'h101010, 24'h808080, 48'h0000C0000000, 24'd0, 24'd0,
                       24'd0, 16'hFFFF};

        // reset state: zero sun direction gives wrap of one half
        rows.push_back('{0, 1, '{255, 255, 255, 7, 0, 0, 0, 0, 0, 0}, '{169, 155, 148, 7}});
        rows.push_back('{0, 1, '{0, 0, 0, 255, 16'h7FFF, 0, 0, 0, 0, 0}, '{0, 0, 0, 255}});
        rows.push_back('{0, 0, '{255, 128, 1, 9, 16'h8000, 16'h8000, 16'h8000,
                             24'h800000, 24'h7FFFFF, 0}, none});
        rows.push_back('{0, 0, '{200, 100, 50, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                             24'h7FFFFF, 24'h800000, 24'h7FFFFF}, none});
        rows.push_back('{0, 0, '{17, 99, 240, 3, 16'd1, 16'hFFFF, 16'd0, 0, 0, 0}, none});
        // lighting off passes the base color through
        rows.push_back('{1, 1, '{255, 255, 255, 255, 16'h7FFF, 0, 0, 0, 0, 0},
                         '{255, 255, 255, 255}});
        rows.push_back('{1, 1, '{0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000,
                             24'h800000, 24'h800000, 24'h800000}, '{0, 0, 0, 0}});
        rows.push_back('{1, 1, '{12, 34, 56, 78, 0, 0, 0, 24'h7FFFFF, 0, 0},
                         '{12, 34, 56, 78}});
        // lamp: vertex at the light, below it facing up and down, zero normal, far away
        rows.push_back('{2, 0, '{200, 200, 200, 1, 0, 16'h4000, 0, 0, 0, 0}, none});
        rows.push_back('{2, 0, '{200, 200, 200, 2, 0, 16'h4000, 0, 0, 24'hFFF000, 0}, none});
        rows.push_back('{2, 0, '{200, 200, 200, 3, 0, 16'hC000, 0, 0, 24'hFFF000, 0}, none});
        rows.push_back('{2, 0, '{255, 255, 255, 4, 0, 0, 0, 0, 24'hFFFF00, 0}, none});
        rows.push_back('{2, 0, '{255, 255, 255, 5, 16'h2000, 16'h2000, 0,
                             24'hFFF000, 24'hFFF000, 24'h000800}, none});
        rows.push_back('{2, 0, '{255, 255, 255, 6, 0, 16'h7FFF, 0,
                             24'h800000, 24'h800000, 24'h800000}, none});
        rows.push_back('{2, 0, '{255, 255, 255, 8, 0, 16'd1, 0, 0, 24'hFFFFFF, 0}, none});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        last = 0;
        foreach (rows[i])
        begin
            if (rows[i].setting != last)
            begin
                start <= 1'b0;
                load_setting(presets[rows[i].setting]);
                last = rows[i].setting;
            end
            send_vertex(rows[i].v, rows[i].c, rows[i].fixed, 1'b0);
        end

        for (int k = 0; k < 8; k++)
        begin
            start <= 1'b0;
            load_setting(random_setting(k));
            steady = (k % 3 == 2);
            repeat (50)
            begin
                hit = (cur.inten != 0) && ($urandom_range(0, 19) == 0);
                v.r  = 8'($urandom);
                v.g  = 8'($urandom);
                v.b  = 8'($urandom);
                v.a  = 8'($urandom);
                v.nx = random_normal();
                v.ny = random_normal();
                v.nz = random_normal();
                v.px = random_pos(cur.lx, hit);
                v.py = random_pos(cur.ly, hit);
                v.pz = random_pos(cur.lz, hit);
                send_vertex(v, none, 1'b0, steady);
            end
        end
        start <= 1'b0;

        while (lit_pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
